### rtl/pde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pde_pkg;

    localparam int CoordWidth = 16;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 16;
    localparam int QueueDepthDefault = 4;

    // Distances and radius are squared Q12.4 values, so Q24.8 in 32 bits.
    localparam int SquareWidth = 32;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } cfg_index_t;

    // Classified vertex passed from the front end to the back end.
    typedef struct packed {
        logic [CoordWidth-1:0] x;
        logic [CoordWidth-1:0] y;
        logic                  final_vertex;
        logic                  erased;
    } vertex_t;

    typedef struct packed {
        logic [CoordWidth-1:0] x;
        logic [CoordWidth-1:0] y;
        logic                  segment_end;
        logic                  batch_last;
    } result_t;

endpackage

`default_nettype wire

### rtl/polyline_disc_eraser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Polyline disc eraser. Vertices stream in on the in_valid/in_ready channel, one
// per cycle while in_ready is high, with final_vertex set on the last vertex of
// each polyline. Each vertex whose squared distance from (center_x, center_y) is
// at most radius squared is erased; the survivors are grouped into runs, runs of
// fewer than two vertices are dropped, and every vertex of a longer run leaves on
// the out channel with segment_end set on the run's last vertex and batch_last on
// the last result of each input vertex. A survivor is held back until the next
// vertex arrives, so results trail their vertex by one input. Throughput is one
// vertex per cycle unless stalled; a final vertex that closes a run yields two
// results and stalls the queue while the second waits. A result reaches the
// output register at the earliest once the vertex that causes it has passed the
// squares register and the queue. The queue (QUEUE_DEPTH entries) absorbs output
// stalls. Registers are written through cfg_write/cfg_index/cfg_data only while
// the block is idle; the user must keep to this, as the block does not enforce it.
module polyline_disc_eraser_core
    import pde_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CoordWidth-1:0]    point_x,
    input  wire logic [CoordWidth-1:0]    point_y,
    input  wire logic                     final_vertex,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [CoordWidth-1:0]         kept_x,
    output logic [CoordWidth-1:0]         kept_y,
    output logic                          segment_end,
    output logic                          batch_last
);

    logic    push_valid;
    logic    push_ready;
    vertex_t push_item;
    logic    pop_valid;
    logic    pop_ready;
    vertex_t pop_item;
    result_t out_result;

    pde_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .final_vertex (final_vertex),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    pde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pde_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign kept_x      = out_result.x;
    assign kept_y      = out_result.y;
    assign segment_end = out_result.segment_end;
    assign batch_last  = out_result.batch_last;

endmodule

`default_nettype wire

### rtl/pde_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pde_front
    import pde_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CoordWidth-1:0]    point_x,
    input  wire logic [CoordWidth-1:0]    point_y,
    input  wire logic                     final_vertex,
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output vertex_t                       push_item
);

    logic [CoordWidth-1:0]  center_x_reg;
    logic [CoordWidth-1:0]  center_y_reg;
    logic [CoordWidth-1:0]  radius_reg;

    logic                   stage_valid_reg;
    logic                   stage_valid_next;
    logic [CoordWidth-1:0]  px_reg;
    logic [CoordWidth-1:0]  py_reg;
    logic                   final_reg;
    logic [SquareWidth-1:0] dxsq_reg;
    logic [SquareWidth-1:0] dysq_reg;
    logic [SquareWidth-1:0] r2_reg;
    logic [SquareWidth-1:0] dxsq_next;
    logic [SquareWidth-1:0] dysq_next;
    logic [SquareWidth-1:0] r2_next;

    logic signed [CoordWidth:0]       dx;
    logic signed [CoordWidth:0]       dy;
    logic signed [2*CoordWidth+1:0]   dx_prod;
    logic signed [2*CoordWidth+1:0]   dy_prod;
    logic        [2*CoordWidth-1:0]   r_prod;
    logic        [SquareWidth:0]      dist_sum;
    logic                             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        dx = $signed({center_x_reg[CoordWidth-1], center_x_reg})
           - $signed({point_x[CoordWidth-1], point_x});
        dy = $signed({center_y_reg[CoordWidth-1], center_y_reg})
           - $signed({point_y[CoordWidth-1], point_y});
        dx_prod = dx * dx;
        dy_prod = dy * dy;
        r_prod  = radius_reg * radius_reg;
        // Squares of a 17-bit difference fit in 32 unsigned bits.
        dxsq_next = dx_prod[SquareWidth-1:0];
        dysq_next = dy_prod[SquareWidth-1:0];
        r2_next   = r_prod[SquareWidth-1:0];
    end

    assign in_ready = !stage_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= point_x;
            py_reg    <= point_y;
            final_reg <= final_vertex;
            dxsq_reg  <= dxsq_next;
            dysq_reg  <= dysq_next;
            r2_reg    <= r2_next;
        end
    end

    assign dist_sum = {1'b0, dxsq_reg} + {1'b0, dysq_reg};

    assign push_valid             = stage_valid_reg;
    assign push_item.x            = px_reg;
    assign push_item.y            = py_reg;
    assign push_item.final_vertex = final_reg;
    assign push_item.erased       = dist_sum <= {1'b0, r2_reg};

endmodule

`default_nettype wire

### rtl/pde_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pde_queue
    import pde_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire vertex_t push_item,
    output logic         pop_valid,
    input  wire logic    pop_ready,
    output vertex_t      pop_item
);

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);

    vertex_t                entry_reg [DEPTH];
    logic [PtrWidth-1:0]    wr_ptr_reg;
    logic [PtrWidth-1:0]    wr_ptr_next;
    logic [PtrWidth-1:0]    rd_ptr_reg;
    logic [PtrWidth-1:0]    rd_ptr_next;
    logic [CountWidth-1:0]  count_reg;
    logic [CountWidth-1:0]  count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != CountWidth'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/pde_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pde_back
    import pde_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pop_valid,
    output logic         pop_ready,
    input  wire vertex_t pop_item,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic [CoordWidth-1:0] held_x_reg;
    logic [CoordWidth-1:0] held_y_reg;
    logic [1:0]            run_len_reg;
    logic [CoordWidth-1:0] held_x_next;
    logic [CoordWidth-1:0] held_y_next;
    logic [1:0]            run_len_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    result_t               pend_reg;
    result_t               pend_next;

    logic                  slot_free;
    logic                  do_pop;
    logic                  first_hit;
    logic                  second_hit;
    logic [1:0]            run_after;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = slot_free && !pend_valid_reg;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        run_len_next    = run_len_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        first_hit       = 1'b0;
        second_hit      = 1'b0;
        run_after       = run_len_reg;

        if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        else if (do_pop)
        begin
            out_next.x           = held_x_reg;
            out_next.y           = held_y_reg;
            out_next.segment_end = pop_item.erased;
            if (pop_item.erased)
            begin
                // Held vertex closes a run only if the run has two or more.
                first_hit = run_len_reg == 2'd2;
                run_after = 2'd0;
            end
            else
            begin
                first_hit   = run_len_reg != 2'd0;
                run_after   = (run_len_reg == 2'd2) ? 2'd2 : run_len_reg + 1'b1;
                held_x_next = pop_item.x;
                held_y_next = pop_item.y;
            end

            second_hit = pop_item.final_vertex && run_after == 2'd2;
            out_next.batch_last = !second_hit;
            out_valid_next      = first_hit;

            pend_valid_next       = second_hit;
            pend_next.x           = held_x_next;
            pend_next.y           = held_y_next;
            pend_next.segment_end = 1'b1;
            pend_next.batch_last  = 1'b1;

            run_len_next = run_after;
            if (pop_item.final_vertex)
            begin
                run_len_next = 2'd0;
                held_x_next  = '0;
                held_y_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            run_len_reg    <= 2'd0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            run_len_reg    <= run_len_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pde_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles = 8;
    localparam int TailCycles = 20;
    localparam int RandomPerSetting = 314;
    localparam logic [CfgIndexWidth-1:0] RegUnused = 2'd3;

    typedef struct {
        logic [CoordWidth-1:0] x;
        logic [CoordWidth-1:0] y;
        logic                  last;
    } vertex_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CoordWidth-1:0] point_x = '0;
    logic [CoordWidth-1:0] point_y = '0;
    logic final_vertex = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CoordWidth-1:0] kept_x;
    logic [CoordWidth-1:0] kept_y;
    logic segment_end;
    logic batch_last;

    // Eraser settings and run state as the block should hold them
    logic [CoordWidth-1:0] disc_cx = '0;
    logic [CoordWidth-1:0] disc_cy = '0;
    logic [CoordWidth-1:0] disc_r = '0;
    logic [CoordWidth-1:0] held_px = '0;
    logic [CoordWidth-1:0] held_py = '0;
    int run_len = 0;

    vertex_item_t pending_vertices[$];
    result_t expected_kept[$];
    int mismatches = 0;
    int send_idle_pct = 30;
    int recv_idle_pct = 54;
    int quiet_cycles = 0;

    polyline_disc_eraser_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .final_vertex (final_vertex),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kept_x       (kept_x),
        .kept_y       (kept_y),
        .segment_end  (segment_end),
        .batch_last   (batch_last)
    );

    always #1 clk = ~clk;

    function automatic bit in_disc(logic [CoordWidth-1:0] px, logic [CoordWidth-1:0] py);
        longint dx;
        longint dy;
        longint r2;
        dx = longint'($signed(disc_cx)) - longint'($signed(px));
        dy = longint'($signed(disc_cy)) - longint'($signed(py));
        r2 = longint'(disc_r) * longint'(disc_r);
        return (dx * dx + dy * dy) <= r2;
    endfunction

    task automatic apply_vertex(input logic [CoordWidth-1:0] px, input logic [CoordWidth-1:0] py,
                                input logic last);
        result_t outs[2];
        int n;
        n = 0;
        if (in_disc(px, py))
        begin
            if (run_len >= 2)
            begin
                outs[n] = '{x: held_px, y: held_py, segment_end: 1'b1, batch_last: 1'b0};
                n++;
            end
            run_len = 0;
        end
        else
        begin
            // the run now has two or more vertices, so the held one stays open
            if (run_len >= 1)
            begin
                outs[n] = '{x: held_px, y: held_py, segment_end: 1'b0, batch_last: 1'b0};
                n++;
            end
            held_px = px;
            held_py = py;
            if (run_len < 2)
                run_len++;
        end
        if (last)
        begin
            if (run_len >= 2)
            begin
                outs[n] = '{x: held_px, y: held_py, segment_end: 1'b1, batch_last: 1'b0};
                n++;
            end
            run_len = 0;
            held_px = '0;
            held_py = '0;
        end
        for (int k = 0; k < n; k++)
        begin
            outs[k].batch_last = (k == n - 1);
            expected_kept.push_back(outs[k]);
        end
    endtask

    task automatic note_field(input string name, input logic [CoordWidth-1:0] want,
                              input logic [CoordWidth-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: hold the payload until the transfer, then load the next vertex
    always @(posedge clk)
    begin
        vertex_item_t next_item;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_vertex(point_x, point_y, final_vertex);
            if (!in_valid || in_ready)
            begin
                if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_vertices.pop_front();
                    in_valid <= 1'b1;
                    point_x <= next_item.x;
                    point_y <= next_item.y;
                    final_vertex <= next_item.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_kept.size() == 0)
                begin
                    $display("%0t: unexpected result x=%h y=%h end=%b last=%b", $time,
                             kept_x, kept_y, segment_end, batch_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_kept.pop_front();
                    note_field("kept_x", want.x, kept_x);
                    note_field("kept_y", want.y, kept_y);
                    note_field("segment_end", 16'(want.segment_end), 16'(segment_end));
                    note_field("batch_last", 16'(want.batch_last), 16'(batch_last));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_vertex(input logic [CoordWidth-1:0] x, input logic [CoordWidth-1:0] y,
                               input logic last);
        pending_vertices.push_back('{x: x, y: y, last: last});
    endtask

    function automatic logic [CoordWidth-1:0] near_coord(logic [CoordWidth-1:0] c, int span);
        int offset;
        offset = int'($urandom_range(0, 2 * span)) - span;
        return CoordWidth'(int'($signed(c)) + offset);
    endfunction

    task automatic pick_point(output logic [CoordWidth-1:0] x, output logic [CoordWidth-1:0] y);
        int pick;
        int span;
        int reach;
        pick = $urandom_range(0, 99);
        span = int'(disc_r) + int'(disc_r) / 2 + 4;
        x = disc_cx;
        y = disc_cy;
        if (pick < 15)
        begin
            x = CoordWidth'($urandom);
            y = CoordWidth'($urandom);
        end
        else if (pick < 25)
        begin
            // exactly on the centre: always erased
        end
        else if (pick < 37)
        begin
            // on the rim, or one step outside it
            reach = int'(disc_r) + int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0)
                reach = -reach;
            if ($urandom_range(0, 1) == 0)
                x = CoordWidth'(int'($signed(disc_cx)) + reach);
            else
                y = CoordWidth'(int'($signed(disc_cy)) + reach);
        end
        else
        begin
            x = near_coord(disc_cx, span);
            y = near_coord(disc_cy, span);
        end
    endtask

    task automatic queue_polylines(input int count);
        int len;
        logic [CoordWidth-1:0] x;
        logic [CoordWidth-1:0] y;
        while (count > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            for (int k = 0; k < len && count > 0; k++)
            begin
                pick_point(x, y);
                push_vertex(x, y, (k == len - 1) || (count == 1));
                count--;
            end
        end
    endtask

    task automatic program_reg(input logic [CfgIndexWidth-1:0] idx,
                               input logic [CfgDataWidth-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_CENTER_X: disc_cx = data;
            REG_CENTER_Y: disc_cy = data;
            REG_RADIUS:   disc_r = data;
            default:      ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_vertices.size() != 0 || in_valid || expected_kept.size() != 0);
        // a vertex that yields nothing may still be in the pipeline
        repeat (SettleCycles) @(negedge clk);
    endtask

    initial
    begin
        logic [CfgDataWidth-1:0] cx;
        logic [CfgDataWidth-1:0] cy;
        logic [CfgDataWidth-1:0] r;

        // Reset settings: zero radius, so only the centre itself is erased
        push_vertex(16'h0000, 16'h0000, 1'b0);
        push_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        push_vertex(16'h8000, 16'h8000, 1'b0);
        push_vertex(16'h0000, 16'h0000, 1'b0);
        push_vertex(16'h0001, 16'h0000, 1'b1);
        push_vertex(16'h0005, 16'h0005, 1'b1);
        push_vertex(16'h0010, 16'hFFF0, 1'b0);
        push_vertex(16'hFFFF, 16'h0001, 1'b0);
        push_vertex(16'h0007, 16'h0007, 1'b1);
        push_vertex(16'h0000, 16'h0000, 1'b1);
        push_vertex(16'h0003, 16'h0003, 1'b0);
        push_vertex(16'h0004, 16'h0004, 1'b0);
        push_vertex(16'h0000, 16'h0000, 1'b1);
        push_vertex(16'h8000, 16'h7FFF, 1'b0);
        push_vertex(16'h7FFF, 16'h8000, 1'b0);
        push_vertex(16'hFFFF, 16'hFFFF, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: begin cx = 16'h0100; cy = 16'hFF80; r = 16'h0200; end
                1: begin cx = 16'h7FFF; cy = 16'h8000; r = 16'hFFFF; end
                2: begin cx = 16'h8000; cy = 16'h7FFF; r = 16'h0001; end
                3:
                begin
                    cx = CfgDataWidth'($urandom);
                    cy = CfgDataWidth'($urandom);
                    r = CfgDataWidth'($urandom_range(0, 16'h0800));
                end
                4: begin cx = 16'h0000; cy = 16'h0000; r = 16'h0000; end
                default:
                begin
                    cx = CfgDataWidth'($urandom);
                    cy = CfgDataWidth'($urandom);
                    r = CfgDataWidth'($urandom);
                end
            endcase
            if (s >= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (s >= 2)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 30;
            end
            if (s == 1)
                program_reg(RegUnused, CfgDataWidth'($urandom));
            program_reg(REG_CENTER_X, cx);
            program_reg(REG_CENTER_Y, cy);
            program_reg(REG_RADIUS, r);
            @(posedge clk);
            cfg_write <= 1'b0;
            @(negedge clk);
            queue_polylines(RandomPerSetting);
            wait_drained();
        end

        repeat (TailCycles) @(posedge clk);
        if (expected_kept.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
